// File: sv/mandelbrot_escape_time_pixel_macros.svh
// Assertion macros for the Mandelbrot escape-time pixel block.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every edge outside reset.
`define MEP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Condition in one cycle that forces a condition in the next.
`define MEP_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define MEP_ASSERT(lbl, clk, rst, prop)
`define MEP_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// File: sv/mep_pkg.sv
// Shared types, widths and constants of the Mandelbrot escape-time pixel block.
// Used by mep_core and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mep_pkg;

   localparam int MAX_ITERS_DEFAULT = 255;
   localparam int FRAC_BITS_DEFAULT = 28;

   localparam int PX_WIDTH   = 8;
   localparam int PY_WIDTH   = 7;
   localparam int GRAY_WIDTH = 8;
   localparam int MUL_WIDTH  = 32;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;
   localparam int C_WIDTH    = 41;
   localparam int Z_WIDTH    = 42;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_REAL = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORIGIN_IMAG = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_REAL   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_IMAG   = 3'd3;

   localparam logic signed [31:0] ORIGIN_REAL_RESET = -32'sd268435456;
   localparam logic signed [31:0] ORIGIN_IMAG_RESET = 32'sd268435456;
   localparam logic [30:0]        STEP_REAL_RESET   = 31'd3355443;
   localparam logic [30:0]        STEP_IMAG_RESET   = 31'd6710886;

   typedef struct packed {
      logic signed [31:0] origin_real;
      logic signed [31:0] origin_imag;
      logic [30:0]        step_real;
      logic [30:0]        step_imag;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic ack;
   } core_ctl_type;

   typedef struct packed {
      logic                  idle;
      logic                  done;
      logic [GRAY_WIDTH-1:0] gray_level;
      logic                  escaped;
   } core_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_C_R,
      ST_C_I,
      ST_Z_INIT,
      ST_UPDATE,
      ST_SQ_R,
      ST_SQ_I,
      ST_MUL_RI,
      ST_HOLD
   } state_type;

endpackage
`default_nettype wire

// File: sv/mep_core.sv
// Iteration core: forms c from the pixel and runs z = z*z + c on one shared multiplier.
// Depends on mep_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_pixel_macros.svh"
module mep_core #(
   parameter int MAX_ITERS = mep_pkg::MAX_ITERS_DEFAULT,
   parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mep_pkg::core_ctl_type          ctl,
   input  wire logic [mep_pkg::PX_WIDTH-1:0]   pixel_x,
   input  wire logic [mep_pkg::PY_WIDTH-1:0]   pixel_y,
   input  wire mep_pkg::cfg_type               cfg,
   output mep_pkg::core_sts_type               sts
);

   localparam int MW = mep_pkg::MUL_WIDTH;
   localparam int PW = mep_pkg::PROD_WIDTH;
   localparam int CW = mep_pkg::C_WIDTH;
   localparam int ZW = mep_pkg::Z_WIDTH;
   localparam int GW = mep_pkg::GRAY_WIDTH;

   localparam logic signed [ZW-1:0] BOUND = ZW'(64'sd1 << (FRAC_BITS + 1));
   localparam logic signed [PW:0]   LIMIT = (PW+1)'(65'sd1 << (2 * FRAC_BITS + 2));
   localparam logic [GW-1:0]        ITER_LAST = GW'(MAX_ITERS);

   mep_pkg::state_type state_ff, state_in;

   logic [mep_pkg::PX_WIDTH-1:0] px_ff, px_in;
   logic [mep_pkg::PY_WIDTH-1:0] py_ff, py_in;
   logic signed [CW-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [ZW-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PW-1:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [GW-1:0]        k_ff, k_in;
   logic [GW-1:0]        gray_ff, gray_in;
   logic                 esc_ff, esc_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic signed [PW:0]   diff_r, twice_ri, sh_r, sh_i, mag;
   logic                 out_bound, out_mag;

   // shared multiplier, result always registered by the consumer
   assign prod = mul_a * mul_b;

   assign diff_r   = (PW+1)'(rr_ff) - (PW+1)'(ii_ff);
   assign twice_ri = {ri_ff, 1'b0};
   assign sh_r     = diff_r >>> FRAC_BITS;
   assign sh_i     = twice_ri >>> FRAC_BITS;
   assign mag      = (PW+1)'(rr_ff) + (PW+1)'(ii_ff);
   assign out_mag  = mag > LIMIT;
   assign out_bound = (zr_ff > BOUND) || (zr_ff < -BOUND) ||
                      (zi_ff > BOUND) || (zi_ff < -BOUND);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mep_pkg::ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      rr_ff   <= rr_in;
      ii_ff   <= ii_in;
      ri_ff   <= ri_in;
      gray_ff <= gray_in;
      esc_ff  <= esc_in;
   end

   always_comb begin
      state_in = state_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      ri_in    = ri_ff;
      k_in     = k_ff;
      gray_in  = gray_ff;
      esc_in   = esc_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (state_ff)
         mep_pkg::ST_IDLE: begin
            if (ctl.start) begin
               px_in    = pixel_x;
               py_in    = pixel_y;
               state_in = mep_pkg::ST_C_R;
            end
         end
         mep_pkg::ST_C_R: begin
            mul_a    = MW'(px_ff);
            mul_b    = MW'(cfg.step_real);
            rr_in    = prod;
            state_in = mep_pkg::ST_C_I;
         end
         mep_pkg::ST_C_I: begin
            cr_in    = CW'(cfg.origin_real) + $signed(rr_ff[CW-1:0]);
            mul_a    = MW'(py_ff);
            mul_b    = MW'(cfg.step_imag);
            rr_in    = prod;
            state_in = mep_pkg::ST_Z_INIT;
         end
         mep_pkg::ST_Z_INIT: begin
            // z starts at zero, so its products are zero as well
            ci_in    = CW'(cfg.origin_imag) - $signed(rr_ff[CW-1:0]);
            rr_in    = '0;
            ii_in    = '0;
            ri_in    = '0;
            k_in     = '0;
            state_in = mep_pkg::ST_UPDATE;
         end
         mep_pkg::ST_UPDATE: begin
            zr_in    = $signed(sh_r[ZW-1:0]) + ZW'(cr_ff);
            zi_in    = $signed(sh_i[ZW-1:0]) + ZW'(ci_ff);
            k_in     = k_ff + GW'(1);
            state_in = mep_pkg::ST_SQ_R;
         end
         mep_pkg::ST_SQ_R: begin
            // a part beyond 2.0 escapes before it reaches the multiplier
            if (out_bound) begin
               gray_in  = k_ff - GW'(1);
               esc_in   = 1'b1;
               state_in = mep_pkg::ST_HOLD;
            end else begin
               mul_a    = zr_ff[MW-1:0];
               mul_b    = zr_ff[MW-1:0];
               rr_in    = prod;
               state_in = mep_pkg::ST_SQ_I;
            end
         end
         mep_pkg::ST_SQ_I: begin
            mul_a    = zi_ff[MW-1:0];
            mul_b    = zi_ff[MW-1:0];
            ii_in    = prod;
            state_in = mep_pkg::ST_MUL_RI;
         end
         mep_pkg::ST_MUL_RI: begin
            mul_a = zr_ff[MW-1:0];
            mul_b = zi_ff[MW-1:0];
            ri_in = prod;
            if (out_mag) begin
               gray_in  = k_ff - GW'(1);
               esc_in   = 1'b1;
               state_in = mep_pkg::ST_HOLD;
            end else if (k_ff == ITER_LAST) begin
               gray_in  = ITER_LAST;
               esc_in   = 1'b0;
               state_in = mep_pkg::ST_HOLD;
            end else begin
               state_in = mep_pkg::ST_UPDATE;
            end
         end
         mep_pkg::ST_HOLD: begin
            if (ctl.ack) begin
               state_in = mep_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mep_pkg::ST_IDLE;
         end
      endcase
   end

   assign sts.idle       = (state_ff == mep_pkg::ST_IDLE);
   assign sts.done       = (state_ff == mep_pkg::ST_HOLD);
   assign sts.gray_level = gray_ff;
   assign sts.escaped    = esc_ff;

   `MEP_ASSERT(a_iter_in_range, clock, reset, k_ff <= ITER_LAST)
   `MEP_ASSERT(a_sq_after_update, clock, reset, (state_ff != mep_pkg::ST_SQ_R) || (k_ff != '0))
   `MEP_ASSERT(a_no_escape_full, clock, reset, !sts.done || sts.escaped || (gray_ff == ITER_LAST))

endmodule
`default_nettype wire

// File: sv/mandelbrot_escape_time_pixel.sv
// Top level of the Mandelbrot escape-time pixel block: stream ports, registers, result register.
// Depends on mep_pkg, mep_core and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_time_pixel_macros.svh"
// Usage
//   req_*: one pixel coordinate per transfer (column and row). The block takes a
//     transfer only while its iteration core is idle and reset is low.
//   rsp_*: one result per pixel: iterations completed before escape (MAX_ITERS
//     if none) and the escaped flag.
//   csr_*: write-only register port; write only while no pixel is in flight.
//     Indexes beyond the four registers are ignored.
// Sequence
//   The core has one 32x32 multiplier that serves every product, so each update
//   of z steps through update, zr*zr, zi*zi and zr*zi with the magnitude test.
//   Forming c runs through C_R, C_I and Z_INIT first, and the result then waits
//   in HOLD for handover; the core takes no new pixel until it has handed its
//   result over. The result is visible in the cycle after handover.
// Stall and reset
//   A finished result waits in the output register; the core accepts the next
//   pixel meanwhile and holds its own result until that register frees up.
//   Synchronous reset returns the core to idle, drops any pending result and
//   restores the register reset values (origin -1+1i, steps 2/160 and 2/80).
module mandelbrot_escape_time_pixel #(
   parameter int MAX_ITERS = mep_pkg::MAX_ITERS_DEFAULT,
   parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output      logic                                  req_tready,
   input  wire logic [15:0]                           req_tdata,  // pixel_x[7:0], pixel_y[14:8]
   output      logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output      logic [15:0]                           rsp_tdata,  // gray_level[7:0], escaped[8]
   input  wire logic                                  csr_we,
   input  wire logic [mep_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [mep_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   mep_pkg::cfg_type      cfg_ff;
   mep_pkg::core_ctl_type ctl;
   mep_pkg::core_sts_type sts;

   logic                               rsp_valid_ff;
   logic [mep_pkg::GRAY_WIDTH-1:0]     gray_ff;
   logic                               esc_ff;

   // configuration registers; bits above a register's width are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_real <= mep_pkg::ORIGIN_REAL_RESET;
         cfg_ff.origin_imag <= mep_pkg::ORIGIN_IMAG_RESET;
         cfg_ff.step_real   <= mep_pkg::STEP_REAL_RESET;
         cfg_ff.step_imag   <= mep_pkg::STEP_IMAG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mep_pkg::CSR_ORIGIN_REAL: cfg_ff.origin_real <= $signed(csr_wdata);
            mep_pkg::CSR_ORIGIN_IMAG: cfg_ff.origin_imag <= $signed(csr_wdata);
            mep_pkg::CSR_STEP_REAL:   cfg_ff.step_real   <= csr_wdata[30:0];
            mep_pkg::CSR_STEP_IMAG:   cfg_ff.step_imag   <= csr_wdata[30:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // take a pixel whenever the core is idle outside reset; hand over a result
   // when the output register is empty or being drained this cycle
   assign req_tready = sts.idle && !reset;
   assign ctl.start  = req_tvalid && req_tready;
   assign ctl.ack    = sts.done && (!rsp_valid_ff || rsp_tready);

   mep_core #(
      .MAX_ITERS (MAX_ITERS),
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .pixel_x (req_tdata[7:0]),
      .pixel_y (req_tdata[14:8]),
      .cfg     (cfg_ff),
      .sts     (sts)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ack) begin
         gray_ff <= sts.gray_level;
         esc_ff  <= sts.escaped;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, esc_ff, gray_ff};

   `MEP_ASSERT_NEXT(a_busy_after_start, clock, reset, ctl.start, !req_tready)
   `MEP_ASSERT_NEXT(a_ack_fills_output, clock, reset, ctl.ack, rsp_tvalid)
   `MEP_ASSERT_NEXT(a_core_holds_result, clock, reset, sts.done && !ctl.ack, sts.done)

endmodule
`default_nettype wire

// File: tb/mandelbrot_escape_time_pixel_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time_pixel: streams pixel coordinates under
// several views and idle patterns, predicts each escape count and checks the result stream.
// Depends on mep_pkg and the block's RTL.
module mandelbrot_escape_time_pixel_tb;
   import mep_pkg::*;

   localparam int ITER_LIMIT = MAX_ITERS_DEFAULT;
   localparam int FRAC       = FRAC_BITS_DEFAULT;
   localparam int ONE        = 1 << FRAC;      // 1.0 in Q4.28
   // Slowest legal run: roughly 730 pixels that all run every update, with both sides
   // stalling on top; allow several times that.
   localparam longint CYCLE_LIMIT = 6_000_000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PIXELS_PER_PHASE = 90;

   typedef struct packed {
      logic [GRAY_WIDTH-1:0] gray_level;
      logic                  escaped;
   } escape_result_t;

   // Mirror of the register file plus the queue of escape results still owed by the block.
   class escape_scoreboard;
      logic signed [31:0] origin_re;
      logic signed [31:0] origin_im;
      logic [30:0]        step_re;
      logic [30:0]        step_im;
      escape_result_t     owed_results[$];
      int                 errors;

      function new();
         origin_re = ORIGIN_REAL_RESET;
         origin_im = ORIGIN_IMAG_RESET;
         step_re   = STEP_REAL_RESET;
         step_im   = STEP_IMAG_RESET;
         errors    = 0;
      endfunction

      // Indexes past the last register fall through; upper data bits of the steps drop.
      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_ORIGIN_REAL: origin_re = data;
            CSR_ORIGIN_IMAG: origin_im = data;
            CSR_STEP_REAL:   step_re   = data[30:0];
            CSR_STEP_IMAG:   step_im   = data[30:0];
            default: ;
         endcase
      endfunction

      // Run z = z*z + c from zero and report the update that first leaves radius two.
      function escape_result_t escape_time(logic [PX_WIDTH-1:0] px, logic [PY_WIDTH-1:0] py);
         longint c_re, c_im, z_re, z_im, n_re, n_im, bound, mag_limit;
         int k;
         escape_result_t r;
         bound     = longint'(2) <<< FRAC;
         mag_limit = longint'(1) <<< (2 * FRAC + 2);
         c_re = longint'(origin_re) + longint'(px) * longint'(step_re);
         c_im = longint'(origin_im) - longint'(py) * longint'(step_im);
         z_re = 0;
         z_im = 0;
         r.gray_level = GRAY_WIDTH'(ITER_LIMIT);
         r.escaped    = 1'b0;
         for (k = 0; k < ITER_LIMIT; k++) begin
            // >>> on a signed value floors toward minus infinity
            n_re = ((z_re * z_re - z_im * z_im) >>> FRAC) + c_re;
            n_im = ((2 * z_re * z_im) >>> FRAC) + c_im;
            z_re = n_re;
            z_im = n_im;
            // a part beyond 2.0 escapes before any square could overflow
            if (z_re > bound || z_re < -bound || z_im > bound || z_im < -bound ||
                z_re * z_re + z_im * z_im > mag_limit) begin
               r.gray_level = GRAY_WIDTH'(k);
               r.escaped    = 1'b1;
               break;
            end
         end
         return r;
      endfunction

      function void note_pixel(logic [PX_WIDTH-1:0] px, logic [PY_WIDTH-1:0] py);
         owed_results.push_back(escape_time(px, py));
      endfunction

      function void check_pixel(logic [GRAY_WIDTH-1:0] gray, logic esc);
         escape_result_t want;
         if (owed_results.size() == 0) begin
            $error("result with nothing owed: gray_level %0d, escaped %0d", gray, esc);
            errors++;
         end else begin
            want = owed_results.pop_front();
            if (gray !== want.gray_level) begin
               $error("gray_level mismatch: expected %0d, actual %0d", want.gray_level, gray);
               errors++;
            end
            if (esc !== want.escaped) begin
               $error("escaped mismatch: expected %0d, actual %0d", want.escaped, esc);
               errors++;
            end
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [15:0]                req_tdata = '0;   // pixel_x[7:0], pixel_y[14:8]
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [15:0]                rsp_tdata;        // gray_level[7:0], escaped[8]
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int             send_idle_pct  = 0;
   int             recv_stall_pct = 0;
   longint         cycles = 0;
   escape_scoreboard board;

   mandelbrot_escape_time_pixel i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: values read right after the edge are the ones the edge sampled,
   // so a transfer is valid && ready as seen here. Re-roll the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_pixel(rsp_tdata[GRAY_WIDTH-1:0], rsp_tdata[GRAY_WIDTH]);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offer one pixel and hold it until the block takes the transfer. The valid is only
   // dropped when an idle cycle is drawn, so back-to-back pixels keep it high.
   task automatic send_pixel(input logic [PX_WIDTH-1:0] px, input logic [PY_WIDTH-1:0] py);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, py, px};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      board.note_pixel(px, py);
   endtask

   // Drop the valid and wait until every owed result has come back, then a little more.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.owed_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One register write per edge; the enable stays high across a burst of writes.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      board.write_reg(index, data);
   endtask

   // Load a full view while idle; a stray write to an unused index rides along each time.
   task automatic program_view(input logic [31:0] ore, input logic [31:0] oim,
                               input logic [31:0] sre, input logic [31:0] sim);
      wait_drained();
      write_csr(CSR_ORIGIN_REAL, ore);
      write_csr(CSR_ORIGIN_IMAG, oim);
      write_csr(CSR_STEP_REAL, sre);
      write_csr(CSR_STEP_IMAG, sim);
      write_csr(CSR_INDEX_WIDTH'(CSR_STEP_IMAG + 1 + $urandom_range(3)), $urandom);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pick_view(input int kind);
      logic [31:0] ore, oim, sre, sim;
      case (kind)
         0: begin
            // whole set: -2.5..+1.0 by +1.25..-1.25
            ore = 32'(-5 * ONE / 2);
            oim = 32'(5 * ONE / 4);
            sre = 32'd5872025;
            sim = 32'd8388608;
         end
         1: begin
            // random window of modest size around the set
            ore = 32'($urandom_range(5 * ONE / 2)) - 32'(2 * ONE);
            oim = 32'($urandom_range(2 * ONE)) - 32'(ONE);
            sre = 32'($urandom_range(1 << 20, 1));
            sim = 32'($urandom_range(1 << 20, 1));
         end
         2: begin
            ore = ORIGIN_REAL_RESET;
            oim = ORIGIN_IMAG_RESET;
            sre = {1'b0, STEP_REAL_RESET};
            sim = {1'b0, STEP_IMAG_RESET};
         end
         3: begin
            // anything at all; mostly points far outside
            ore = $urandom;
            oim = $urandom;
            sre = $urandom;
            sim = $urandom;
         end
         default: begin
            // deep zoom near the boundary west of the cardioid: long, uneven escapes
            ore = 32'(-214748365);
            oim = 32'(53687091);
            sre = 32'($urandom_range(1 << 14, 1 << 10));
            sim = 32'($urandom_range(1 << 14, 1 << 10));
         end
      endcase
      // the step registers are 31 bits wide; set the dropped bit at random
      sre[31] = 1'($urandom_range(1));
      sim[31] = 1'($urandom_range(1));
      program_view(ore, oim, sre, sim);
   endtask

   initial begin
      logic [PX_WIDTH-1:0] px;
      logic [PY_WIDTH-1:0] py;
      int phase;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset view, corners, frame center (c near zero never escapes),
      // pixels past the frame edge and the field extremes.
      send_pixel(8'd0, 7'd0);
      send_pixel(8'd159, 7'd79);
      send_pixel(8'd80, 7'd40);
      send_pixel(8'd160, 7'd80);
      send_pixel(8'd255, 7'd127);
      send_pixel(8'd0, 7'd127);
      send_pixel(8'd255, 7'd0);

      // c = -2 exactly sits on the circle forever: |z|^2 == 4 is not an escape
      program_view(32'(-2 * ONE), 32'd0, 32'd0, 32'd0);
      send_pixel(8'd0, 7'd0);
      send_pixel(8'd200, 7'd100);

      // c = +2 meets the circle first, then leaves on the next update
      program_view(32'(2 * ONE), 32'd0, 32'd0, 32'd0);
      send_pixel(8'd37, 7'd5);

      // widest registers: huge c escapes on the first update; step bit 31 is dropped
      program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(8'd0, 7'd0);
      send_pixel(8'd255, 7'd127);
      send_pixel(8'd255, 7'd0);
      send_pixel(8'd0, 7'd127);

      program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
      send_pixel(8'd255, 7'd127);
      send_pixel(8'd1, 7'd1);

      // Random: each phase loads a view, picks an idle pattern and streams pixels,
      // mostly inside the frame and some anywhere in the field range.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0, 6:    pick_view(0);
            1, 5:    pick_view(1);
            2:       pick_view(2);
            3, 7:    pick_view(3);
            default: pick_view(4);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         repeat (PIXELS_PER_PHASE) begin
            if ($urandom_range(99) < 85) begin
               px = PX_WIDTH'($urandom_range(159));
               py = PY_WIDTH'($urandom_range(79));
            end else begin
               px = PX_WIDTH'($urandom_range(255));
               py = PY_WIDTH'($urandom_range(127));
            end
            send_pixel(px, py);
         end
      end

      // Let the last result drain, then allow a few more edges for anything stray.
      wait_drained();
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
